/* rtl/csma_pkg.sv */
// shared types, constants and helpers of the csma/ca backoff controller
package csma_pkg;

    localparam int COUNT_WIDTH_DEF = 20;

    localparam int CW_MIN_W   = 10;
    localparam int LIMIT_W    = 4;
    localparam int STAGE_W    = 4;
    localparam int RETRY_W    = 5;
    localparam int DIFS_W     = 4;
    localparam int RAND_W     = 16;
    localparam int PHASE_W    = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [CW_MIN_W-1:0] CW_MIN_RESET        = 10'd16;
    localparam logic [LIMIT_W-1:0]  RETRY_LIMIT_RESET   = 4'd7;
    localparam logic [LIMIT_W-1:0]  BACKOFF_LIMIT_RESET = 4'd6;
    localparam logic [DIFS_W-1:0]   DIFS_SLOTS_RESET    = 4'd5;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_CW_MIN        = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
    localparam logic [1:0] REG_BACKOFF_LIMIT = 2'd2;
    localparam logic [1:0] REG_DIFS_SLOTS    = 2'd3;

    // phase codes as seen on the result beat
    localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DIFS    = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_BACKOFF = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_TX      = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_DIFS    = 4'b0010,
        PH_BACKOFF = 4'b0100,
        PH_TX      = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [CW_MIN_W-1:0] cw_min;
        logic [LIMIT_W-1:0]  retry_limit;
        logic [LIMIT_W-1:0]  backoff_limit;
        logic [DIFS_W-1:0]   difs_slots;
    } cfg_t;

    typedef struct packed {
        logic              channel_busy;
        logic              packet_pending;
        logic              collision_seen;
        logic [RAND_W-1:0] rand_value;
    } item_t;

    typedef struct packed {
        logic transmit_now;
        logic packet_sent;
        logic packet_dropped;
    } events_t;

    function automatic logic [PHASE_W-1:0] phase_code(phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_IDLE:    code = PHASE_CODE_IDLE;
            PH_DIFS:    code = PHASE_CODE_DIFS;
            PH_BACKOFF: code = PHASE_CODE_BACKOFF;
            PH_TX:      code = PHASE_CODE_TX;
            default:    code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* rtl/csma_cfg_regs.sv */
// apb configuration registers of the csma/ca backoff controller
module csma_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csma_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [csma_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [csma_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output csma_pkg::cfg_t                      cfg
);

    csma_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cw_min        <= csma_pkg::CW_MIN_RESET;
            cfg_reg.retry_limit   <= csma_pkg::RETRY_LIMIT_RESET;
            cfg_reg.backoff_limit <= csma_pkg::BACKOFF_LIMIT_RESET;
            cfg_reg.difs_slots    <= csma_pkg::DIFS_SLOTS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                csma_pkg::REG_CW_MIN:
                    cfg_reg.cw_min <= pwdata[csma_pkg::CW_MIN_W-1:0];
                csma_pkg::REG_RETRY_LIMIT:
                    cfg_reg.retry_limit <= pwdata[csma_pkg::LIMIT_W-1:0];
                csma_pkg::REG_BACKOFF_LIMIT:
                    cfg_reg.backoff_limit <= pwdata[csma_pkg::LIMIT_W-1:0];
                csma_pkg::REG_DIFS_SLOTS:
                    cfg_reg.difs_slots <= pwdata[csma_pkg::DIFS_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            csma_pkg::REG_CW_MIN:
                prdata = csma_pkg::APB_DATA_W'(cfg_reg.cw_min);
            csma_pkg::REG_RETRY_LIMIT:
                prdata = csma_pkg::APB_DATA_W'(cfg_reg.retry_limit);
            csma_pkg::REG_BACKOFF_LIMIT:
                prdata = csma_pkg::APB_DATA_W'(cfg_reg.backoff_limit);
            csma_pkg::REG_DIFS_SLOTS:
                prdata = csma_pkg::APB_DATA_W'(cfg_reg.difs_slots);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* rtl/csma_draw.sv */
// backoff count draw: 1 + ((w - 1) * rand) >> 16 with w = cw_min << stage
module csma_draw #(
    parameter int COUNT_WIDTH = csma_pkg::COUNT_WIDTH_DEF
) (
    input  logic [csma_pkg::CW_MIN_W-1:0] cw_min,
    input  logic [csma_pkg::STAGE_W-1:0]  stage,
    input  logic [csma_pkg::RAND_W-1:0]   rand_value,
    output logic [COUNT_WIDTH-1:0]        draw_count
);

    localparam int ShiftW = csma_pkg::CW_MIN_W + (2 ** csma_pkg::STAGE_W) - 1;
    localparam int WideW  = (COUNT_WIDTH > ShiftW) ? COUNT_WIDTH : ShiftW;
    localparam int ProdW  = COUNT_WIDTH + csma_pkg::RAND_W;
    localparam logic [WideW-1:0] CountMax = WideW'({COUNT_WIDTH{1'b1}});

    logic [WideW-1:0]       w_wide;
    logic [COUNT_WIDTH-1:0] w;
    logic [COUNT_WIDTH-1:0] w_less;
    logic [ProdW-1:0]       prod;

    assign w_wide = WideW'(cw_min) << stage;
    // window saturates at the largest count the counter can hold
    assign w      = (w_wide > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                        : w_wide[COUNT_WIDTH-1:0];
    assign w_less = w - COUNT_WIDTH'(1);
    assign prod   = ProdW'(w_less) * ProdW'(rand_value);

    assign draw_count = (w < COUNT_WIDTH'(2)) ? COUNT_WIDTH'(1)
                      : prod[ProdW-1:csma_pkg::RAND_W] + COUNT_WIDTH'(1);

endmodule

/* rtl/csma_access_fsm.sv */
// station access state machine: idle, difs, backoff and transmit slot
module csma_access_fsm #(
    parameter int COUNT_WIDTH = csma_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  csma_pkg::item_t                item,
    input  csma_pkg::cfg_t                 cfg,
    output csma_pkg::events_t              events,
    output logic [csma_pkg::PHASE_W-1:0]   phase_now,
    output logic [COUNT_WIDTH-1:0]         backoff_left,
    output logic [csma_pkg::STAGE_W-1:0]   stage_now,
    output logic [csma_pkg::RETRY_W-1:0]   retries_now
);

    csma_pkg::phase_t               phase_reg, phase_next;
    logic [csma_pkg::DIFS_W-1:0]    difs_reg, difs_next, difs_inc;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic                           armed_reg, armed_next;
    logic [csma_pkg::STAGE_W-1:0]   stage_reg, stage_next;
    logic [csma_pkg::RETRY_W-1:0]   retry_reg, retry_next, retry_inc;
    logic [csma_pkg::STAGE_W:0]     stage_inc;
    logic [COUNT_WIDTH-1:0]         draw_count;

    csma_draw #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_draw (
        .cw_min     (cfg.cw_min),
        .stage      (stage_reg),
        .rand_value (item.rand_value),
        .draw_count (draw_count)
    );

    assign difs_inc  = difs_reg + csma_pkg::DIFS_W'(1);
    assign retry_inc = retry_reg + csma_pkg::RETRY_W'(1);
    assign stage_inc = {1'b0, stage_reg} + (csma_pkg::STAGE_W + 1)'(1);

    always_comb
    begin
        phase_next = phase_reg;
        difs_next  = difs_reg;
        count_next = count_reg;
        armed_next = armed_reg;
        stage_next = stage_reg;
        retry_next = retry_reg;
        events     = '0;
        unique case (phase_reg)
            csma_pkg::PH_IDLE:
            begin
                if (item.packet_pending)
                begin
                    phase_next = csma_pkg::PH_DIFS;
                    difs_next  = '0;
                end
            end
            csma_pkg::PH_DIFS:
            begin
                if (item.channel_busy)
                begin
                    difs_next = '0;
                end
                else
                begin
                    difs_next = difs_inc;
                    if (difs_inc >= cfg.difs_slots)
                    begin
                        difs_next  = '0;
                        // a frozen count from an earlier busy slot is kept
                        if (!armed_reg)
                        begin
                            count_next = draw_count;
                            armed_next = 1'b1;
                        end
                        phase_next = csma_pkg::PH_BACKOFF;
                    end
                end
            end
            csma_pkg::PH_BACKOFF:
            begin
                if (count_reg == '0)
                begin
                    phase_next = csma_pkg::PH_TX;
                end
                else if (item.channel_busy)
                begin
                    phase_next = csma_pkg::PH_DIFS;
                    difs_next  = '0;
                end
                else
                begin
                    count_next = count_reg - COUNT_WIDTH'(1);
                    if (count_reg == COUNT_WIDTH'(1))
                    begin
                        phase_next = csma_pkg::PH_TX;
                    end
                end
            end
            csma_pkg::PH_TX:
            begin
                events.transmit_now = 1'b1;
                armed_next = 1'b0;
                count_next = '0;
                if (item.collision_seen)
                begin
                    retry_next = retry_inc;
                    stage_next = (stage_inc > {1'b0, cfg.backoff_limit}) ?
                                 cfg.backoff_limit : stage_inc[csma_pkg::STAGE_W-1:0];
                    if (retry_inc > {1'b0, cfg.retry_limit})
                    begin
                        events.packet_dropped = 1'b1;
                        retry_next = '0;
                        stage_next = '0;
                    end
                end
                else
                begin
                    events.packet_sent = 1'b1;
                    retry_next = '0;
                    stage_next = '0;
                end
                phase_next = csma_pkg::PH_IDLE;
                difs_next  = '0;
            end
            default:
            begin
                phase_next = csma_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= csma_pkg::PH_IDLE;
            difs_reg  <= '0;
            count_reg <= '0;
            armed_reg <= 1'b0;
            stage_reg <= '0;
            retry_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            difs_reg  <= difs_next;
            count_reg <= count_next;
            armed_reg <= armed_next;
            stage_reg <= stage_next;
            retry_reg <= retry_next;
        end
    end

    // result fields carry the state after this slot's update
    assign phase_now    = csma_pkg::phase_code(phase_next);
    assign backoff_left = count_next;
    assign stage_now    = stage_next;
    assign retries_now  = retry_next;

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == csma_pkg::PH_IDLE) |-> (!armed_reg && count_reg == '0))
        else $error("idle phase with a backoff still armed");

    a_armed_in_access: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == csma_pkg::PH_BACKOFF || phase_reg == csma_pkg::PH_TX) |-> armed_reg)
        else $error("backoff or transmit phase without an armed count");

    a_tx_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == csma_pkg::PH_TX) |=> (phase_reg == csma_pkg::PH_IDLE))
        else $error("transmit slot did not return to idle");

    a_event_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (events.packet_sent || events.packet_dropped) |->
        (events.transmit_now && !(events.packet_sent && events.packet_dropped)))
        else $error("sent or dropped outside a single transmit attempt");

endmodule

/* rtl/csma_ca_backoff_controller.sv */
// top level of the csma/ca backoff controller: stream ports and slot register stages
//
// One input beat is one slot tick and gives exactly one result beat. Beats are
// taken in every cycle that the result side does not stall: a slot beat lands
// in the input register, then the access state machine and the backoff draw
// (one multiplier of COUNT_WIDTH by 16 bits) update the station state and load
// the result register once it is free; the rate is one beat per cycle while the
// result side keeps taking beats. A stall on the result side holds both registers
// and is passed back through s_tready. The user must write configuration through
// the apb port only while no slot is in flight; the block does not enforce this.
module csma_ca_backoff_controller #(
    parameter int COUNT_WIDTH = csma_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csma_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [csma_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [csma_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // slot beats in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel_busy, packet_pending, collision_seen, rand_value[15:0]
    input  logic [23:0]                         s_tdata,
    // result beats out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // transmit_now, packet_sent, packet_dropped, phase_now[1:0],
    // backoff_left[COUNT_WIDTH-1:0], stage_now[3:0], retries_now[4:0]
    output logic [((COUNT_WIDTH + 14 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OutBits  = COUNT_WIDTH + 14;
    localparam int OutWidth = ((OutBits + 7) / 8) * 8;

    csma_pkg::cfg_t                 cfg;
    csma_pkg::item_t                item_reg;
    logic                           in_valid_reg;
    logic                           out_valid_reg;
    logic [OutWidth-1:0]            out_data_reg;
    logic                           step;
    csma_pkg::events_t              events;
    logic [csma_pkg::PHASE_W-1:0]   phase_now;
    logic [COUNT_WIDTH-1:0]         backoff_left;
    logic [csma_pkg::STAGE_W-1:0]   stage_now;
    logic [csma_pkg::RETRY_W-1:0]   retries_now;

    csma_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a held slot moves on when the result register is free or being emptied
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.channel_busy   <= s_tdata[0];
            item_reg.packet_pending <= s_tdata[1];
            item_reg.collision_seen <= s_tdata[2];
            item_reg.rand_value     <= s_tdata[18:3];
        end
    end

    csma_access_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (item_reg),
        .cfg          (cfg),
        .events       (events),
        .phase_now    (phase_now),
        .backoff_left (backoff_left),
        .stage_now    (stage_now),
        .retries_now  (retries_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= OutWidth'({retries_now, stage_now, backoff_left, phase_now,
                                       events.packet_dropped, events.packet_sent,
                                       events.transmit_now});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* test/testbench.sv */
// self-checking testbench of the csma/ca backoff controller
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W         = csma_pkg::COUNT_WIDTH_DEF;
    localparam int ITEMS_PER_CFG = 300;
    localparam int NUM_CFG       = 6;

    typedef struct packed {
        logic [csma_pkg::RETRY_W-1:0] retries;
        logic [csma_pkg::STAGE_W-1:0] stage;
        logic [CNT_W-1:0]             left;
        logic [csma_pkg::PHASE_W-1:0] phase;
        logic                         dropped;
        logic                         sent;
        logic                         tx;
    } slot_result_t;

    typedef struct {
        csma_pkg::item_t slot;
        bit              fixed;
        slot_result_t    want;
    } slot_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [csma_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [csma_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [csma_pkg::APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // channel_busy, packet_pending, collision_seen, rand_value[15:0]
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // transmit_now, packet_sent, packet_dropped, phase_now[1:0],
    // backoff_left[19:0], stage_now[3:0], retries_now[4:0]
    logic [((CNT_W + 14 + 7) / 8) * 8 - 1:0] m_tdata;

    csma_ca_backoff_controller uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // station model state and its copy of the registers
    logic [csma_pkg::PHASE_W-1:0]  st_phase;
    logic [csma_pkg::DIFS_W-1:0]   st_difs;
    logic [CNT_W-1:0]              st_count;
    logic                          st_armed;
    logic [csma_pkg::STAGE_W-1:0]  st_stage;
    logic [csma_pkg::RETRY_W-1:0]  st_retry;
    logic [csma_pkg::CW_MIN_W-1:0] cfg_cw;
    logic [csma_pkg::LIMIT_W-1:0]  cfg_retry_limit;
    logic [csma_pkg::LIMIT_W-1:0]  cfg_backoff_limit;
    logic [csma_pkg::DIFS_W-1:0]   cfg_difs;

    slot_result_t pending_results[$];
    slot_row_t rows[$];
    int n_errors = 0;
    int n_beats = 0;
    bit calm = 1'b0;
    int busy_pct = 20;

    initial
    begin
        st_phase = csma_pkg::PHASE_CODE_IDLE;
        st_difs = '0;
        st_count = '0;
        st_armed = 1'b0;
        st_stage = '0;
        st_retry = '0;
        cfg_cw = csma_pkg::CW_MIN_RESET;
        cfg_retry_limit = csma_pkg::RETRY_LIMIT_RESET;
        cfg_backoff_limit = csma_pkg::BACKOFF_LIMIT_RESET;
        cfg_difs = csma_pkg::DIFS_SLOTS_RESET;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < 100)
            $display("mismatch: %s", msg);
        n_errors++;
    endtask

    // contention window for the current stage, saturated to the counter width
    function automatic longint unsigned window_size();
        longint unsigned w;
        longint unsigned cmax;
        cmax = (64'd1 << CNT_W) - 1;
        w = 64'(cfg_cw) << st_stage;
        if (w > cmax)
            w = cmax;
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] backoff_draw(
        input logic [csma_pkg::RAND_W-1:0] r);
        longint unsigned w;
        w = window_size();
        if (w < 2)
            return CNT_W'(1);
        return CNT_W'(64'd1 + (((w - 64'd1) * 64'(r)) >> 16));
    endfunction

    function automatic slot_result_t station_step(input csma_pkg::item_t it);
        slot_result_t res;
        logic [csma_pkg::STAGE_W:0] next_stage;
        res = '0;
        unique case (st_phase)
            csma_pkg::PHASE_CODE_IDLE:
            begin
                if (it.packet_pending)
                begin
                    st_phase = csma_pkg::PHASE_CODE_DIFS;
                    st_difs = '0;
                end
            end
            csma_pkg::PHASE_CODE_DIFS:
            begin
                if (it.channel_busy)
                    st_difs = '0;
                else
                begin
                    st_difs = st_difs + 1'b1;
                    if (st_difs >= cfg_difs)
                    begin
                        st_difs = '0;
                        if (!st_armed)
                        begin
                            st_count = backoff_draw(it.rand_value);
                            st_armed = 1'b1;
                        end
                        st_phase = csma_pkg::PHASE_CODE_BACKOFF;
                    end
                end
            end
            csma_pkg::PHASE_CODE_BACKOFF:
            begin
                if (st_count == 0)
                    st_phase = csma_pkg::PHASE_CODE_TX;
                else if (it.channel_busy)
                begin
                    st_phase = csma_pkg::PHASE_CODE_DIFS;
                    st_difs = '0;
                end
                else
                begin
                    st_count = st_count - 1'b1;
                    if (st_count == 0)
                        st_phase = csma_pkg::PHASE_CODE_TX;
                end
            end
            default:
            begin
                res.tx = 1'b1;
                st_armed = 1'b0;
                st_count = '0;
                if (it.collision_seen)
                begin
                    next_stage = {1'b0, st_stage} + 1'b1;
                    st_retry = st_retry + 1'b1;
                    st_stage = (next_stage > {1'b0, cfg_backoff_limit}) ?
                               cfg_backoff_limit : next_stage[csma_pkg::STAGE_W-1:0];
                    if (st_retry > {1'b0, cfg_retry_limit})
                    begin
                        res.dropped = 1'b1;
                        st_retry = '0;
                        st_stage = '0;
                    end
                end
                else
                begin
                    res.sent = 1'b1;
                    st_retry = '0;
                    st_stage = '0;
                end
                st_phase = csma_pkg::PHASE_CODE_IDLE;
                st_difs = '0;
            end
        endcase
        res.phase = st_phase;
        res.left = st_count;
        res.stage = st_stage;
        res.retries = st_retry;
        return res;
    endfunction

    // expected beat of a table row; stage and retries are zero in every such row
    function automatic slot_result_t expect_slot(input logic tx, input logic sent,
                                                 input logic dropped,
                                                 input logic [csma_pkg::PHASE_W-1:0] ph,
                                                 input logic [CNT_W-1:0] left);
        slot_result_t res;
        res = '0;
        res.tx = tx;
        res.sent = sent;
        res.dropped = dropped;
        res.phase = ph;
        res.left = left;
        return res;
    endfunction

    task automatic add_row(input logic busy, input logic pend, input logic coll,
                           input logic [csma_pkg::RAND_W-1:0] r, input bit fixed,
                           input slot_result_t want);
        slot_row_t row;
        row.slot.channel_busy = busy;
        row.slot.packet_pending = pend;
        row.slot.collision_seen = coll;
        row.slot.rand_value = r;
        row.fixed = fixed;
        row.want = want;
        rows = {rows, row};
    endtask

    // write a register through apb, then read it back
    task automatic cfg_write(input logic [1:0] idx,
                             input logic [csma_pkg::APB_DATA_W-1:0] val);
        logic [csma_pkg::APB_DATA_W-1:0] mask;
        logic [csma_pkg::APB_DATA_W-1:0] got;
        mask = (idx == csma_pkg::REG_CW_MIN) ? 32'h3FF : 32'hF;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (val & mask))
            report_mismatch($sformatf("register %0d read %0h, wrote %0h", idx, got, val));
        unique case (idx)
            csma_pkg::REG_CW_MIN:        cfg_cw = val[csma_pkg::CW_MIN_W-1:0];
            csma_pkg::REG_RETRY_LIMIT:   cfg_retry_limit = val[csma_pkg::LIMIT_W-1:0];
            csma_pkg::REG_BACKOFF_LIMIT: cfg_backoff_limit = val[csma_pkg::LIMIT_W-1:0];
            csma_pkg::REG_DIFS_SLOTS:    cfg_difs = val[csma_pkg::DIFS_W-1:0];
        endcase
    endtask

    task automatic set_config(input int cw, input int rl, input int bl, input int difs);
        cfg_write(csma_pkg::REG_CW_MIN, csma_pkg::APB_DATA_W'(cw));
        cfg_write(csma_pkg::REG_RETRY_LIMIT, csma_pkg::APB_DATA_W'(rl));
        cfg_write(csma_pkg::REG_BACKOFF_LIMIT, csma_pkg::APB_DATA_W'(bl));
        cfg_write(csma_pkg::REG_DIFS_SLOTS, csma_pkg::APB_DATA_W'(difs));
    endtask

    task automatic send_slot(input csma_pkg::item_t it, input bit fixed,
                             input slot_result_t want);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 8));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, it.rand_value, it.collision_seen, it.packet_pending,
                    it.channel_busy};
        do
            @(posedge clk);
        while (!s_tready);
        want = fixed ? want : station_step(it);
        if (fixed)
            void'(station_step(it));
        pending_results = {pending_results, want};
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_slot(output csma_pkg::item_t it);
        longint unsigned w;
        int unsigned cap;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: every flag free
            it.channel_busy = 1'($urandom_range(0, 1));
            it.packet_pending = 1'($urandom_range(0, 1));
            it.collision_seen = 1'($urandom_range(0, 1));
        end
        else
        begin
            it.channel_busy = ($urandom_range(0, 99) < busy_pct);
            it.packet_pending = ($urandom_range(0, 99) < 85);
            it.collision_seen = 1'($urandom_range(0, 1));
        end
        it.rand_value = 16'($urandom_range(0, 65535));
        // keep drawn counts short when the window is wide
        if (st_phase == csma_pkg::PHASE_CODE_DIFS && !st_armed)
        begin
            w = window_size();
            if (w > 4096)
            begin
                cap = 32'((128 << 16) / (w - 1));
                it.rand_value = 16'($urandom_range(0, (cap > 65535) ? 65535 : cap));
            end
        end
    endtask

    always @(posedge clk)
    begin
        slot_result_t got;
        slot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = slot_result_t'(m_tdata[$bits(slot_result_t)-1:0]);
            if (pending_results.size() == 0)
                report_mismatch($sformatf("beat %0d with no slot waiting", n_beats));
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        {"beat %0d tx %0b/%0b sent %0b/%0b drop %0b/%0b",
                         " ph %0d/%0d left %0d/%0d st %0d/%0d rt %0d/%0d"},
                        n_beats, got.tx, want.tx, got.sent, want.sent, got.dropped,
                        want.dropped, got.phase, want.phase, got.left, want.left,
                        got.stage, want.stage, got.retries, want.retries));
            end
            n_beats++;
        end
    end

    // result side: random stalls per beat
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = calm ? 0 : int'($urandom_range(0, 8));
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        csma_pkg::item_t it;
        int cw;
        int rl;
        int bl;
        int difs;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // short window, no retries, one-slot difs so the table stays short
        set_config(1, 0, 10, 1);

        //      busy  pend  coll  rand      fixed
        //      expected: tx sent drop phase left
        add_row(1'b0, 1'b0, 1'b0, 16'h0000, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_IDLE, CNT_W'(0)));
        // busy and collision mean nothing while idle
        add_row(1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_IDLE, CNT_W'(0)));
        add_row(1'b0, 1'b1, 1'b0, 16'h0000, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_DIFS, CNT_W'(0)));
        // queue empties mid-access, busy restarts difs
        add_row(1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_DIFS, CNT_W'(0)));
        // window below two draws a count of one
        add_row(1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_BACKOFF, CNT_W'(1)));
        // busy freezes the count and goes back to difs
        add_row(1'b1, 1'b0, 1'b0, 16'h0000, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_DIFS, CNT_W'(1)));
        add_row(1'b0, 1'b0, 1'b0, 16'h8000, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_BACKOFF, CNT_W'(1)));
        add_row(1'b0, 1'b0, 1'b0, 16'h0000, 1'b1,
                expect_slot(1'b0, 1'b0, 1'b0, csma_pkg::PHASE_CODE_TX, CNT_W'(0)));
        // collision with no retries left drops the packet
        add_row(1'b1, 1'b1, 1'b1, 16'h0000, 1'b1,
                expect_slot(1'b1, 1'b0, 1'b1, csma_pkg::PHASE_CODE_IDLE, CNT_W'(0)));
        add_row(1'b0, 1'b1, 1'b0, 16'h1234, 1'b0, '0);
        add_row(1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0, '0);
        add_row(1'b0, 1'b0, 1'b0, 16'h0001, 1'b0, '0);
        // transmit slot ignores busy and pending
        add_row(1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b1,
                expect_slot(1'b1, 1'b1, 1'b0, csma_pkg::PHASE_CODE_IDLE, CNT_W'(0)));

        foreach (rows[i])
            send_slot(rows[i].slot, rows[i].fixed, rows[i].want);
        wait_drained();

        for (int p = 0; p < NUM_CFG; p++)
        begin
            case (p)
                0:
                begin
                    cw = int'(csma_pkg::CW_MIN_RESET);
                    rl = int'(csma_pkg::RETRY_LIMIT_RESET);
                    bl = int'(csma_pkg::BACKOFF_LIMIT_RESET);
                    difs = int'(csma_pkg::DIFS_SLOTS_RESET);
                end
                1:
                begin
                    cw = 1;
                    rl = 0;
                    bl = 0;
                    difs = 1;
                end
                2:
                begin
                    cw = 1023;
                    rl = 15;
                    bl = 10;
                    difs = 15;
                end
                3:
                begin
                    // limit lowered under a possibly high stage
                    cw = int'($urandom_range(1, 1023));
                    rl = int'($urandom_range(0, 15));
                    bl = 1;
                    difs = int'($urandom_range(1, 15));
                end
                default:
                begin
                    cw = int'($urandom_range(1, 1023));
                    rl = int'($urandom_range(0, 15));
                    bl = int'($urandom_range(0, 10));
                    difs = int'($urandom_range(1, 15));
                end
            endcase
            set_config(cw, rl, bl, difs);
            busy_pct = (difs > 8) ? int'($urandom_range(2, 10)) : int'($urandom_range(5, 35));
            for (int i = 0; i < ITEMS_PER_CFG; i++)
            begin
                if (i % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // hold off until the pipe is empty, mid-phase
                if (i == ITEMS_PER_CFG / 2)
                    wait_drained();
                random_slot(it);
                send_slot(it, 1'b0, '0);
            end
            wait_drained();
        end

        calm = 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
